// ----- design/wpas_pkg.sv -----
// Shared types and constants for the waypoint arrival sequencer.
`default_nettype none

package wpas_pkg;

    // Route table depth and data widths.
    localparam int MAX_WAYPOINTS = 16;
    localparam int COORD_WIDTH   = 32;
    localparam int DWELL_WIDTH   = 16;

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 5;
    localparam int REACH_W = 31;
    localparam int WPC_W   = 5;
    localparam int IDX_W   = $clog2(MAX_WAYPOINTS + 2);
    localparam int ADDR_W  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (COORD_WIDTH > REACH_W) ? COORD_WIDTH : REACH_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REACH_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WP_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOVER      = 3'd5;

    // Configuration reset values.
    localparam logic [REACH_W-1:0]     REACH_RST = REACH_W'(32768);
    localparam logic [DWELL_WIDTH-1:0] DWELL_RST = DWELL_WIDTH'(10);
    localparam logic [WPC_W-1:0]       WPC_RST   = '0;
    localparam logic [COORD_WIDTH-1:0] HOVER_RST = COORD_WIDTH'(65536);

    typedef struct packed {
        logic [OP_W-1:0]               op;
        logic [SLOT_W-1:0]             slot;
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
    } t_item;

    typedef struct packed {
        logic             arrived;
        logic             route_done;
        logic [WPC_W-1:0] current_index;
    } t_result;

endpackage

`default_nettype wire

// ----- design/waypoint_arrival_sequencer.sv -----
// Top level of the waypoint arrival sequencer: route table, dwell counter and set point index.
`default_nettype none

// Usage
// An item enters on i_item when start is high and busy is low at a rising
// clock edge. Op 0 writes a route waypoint, op 1 checks a position sample
// against the current set point, and op 2 advances to the next set point.
// Every item gives exactly one result on o_result, marked by o_valid for one
// cycle, and the receiver has no way to stall it.
// The item is captured in an input register, and all of its work (table read,
// three axis compares, dwell count and index update) is done in the following
// cycle, when the result register loads. So o_valid is registered behind the
// input register, and one item may enter in every cycle while busy is low.
// Configuration registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data while no item is in flight; indexes beyond the list are ignored.
// A synchronous reset clears the set point index to the hover point, clears
// the dwell counter, loads the register defaults and sets busy, which clears
// at the clock edge after reset is released. The route table is not cleared;
// entries must be written before they are used as a set point.
module waypoint_arrival_sequencer (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            start,
    output logic                           busy,
    input  wpas_pkg::t_item                i_item,
    input  wire                            i_cfg_we,
    input  wire [wpas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [wpas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    output wpas_pkg::t_result              o_result
);
    import wpas_pkg::*;

    // Configuration registers.
    logic [REACH_W-1:0]     r_reach_x;
    logic [REACH_W-1:0]     r_reach_y;
    logic [REACH_W-1:0]     r_reach_z;
    logic [DWELL_WIDTH-1:0] r_dwell_count;
    logic [WPC_W-1:0]       r_wp_count;
    logic [COORD_WIDTH-1:0] r_hover;

    // Route table, one array per axis. Entry k holds waypoint k+1.
    logic [COORD_WIDTH-1:0] r_table_x [MAX_WAYPOINTS];
    logic [COORD_WIDTH-1:0] r_table_y [MAX_WAYPOINTS];
    logic [COORD_WIDTH-1:0] r_table_z [MAX_WAYPOINTS];

    // Sequencing state.
    logic [IDX_W-1:0]       r_cur_idx;
    logic [IDX_W-1:0]       n_cur_idx;
    logic [DWELL_WIDTH-1:0] r_dwell;
    logic [DWELL_WIDTH-1:0] n_dwell;

    // Input register and result register.
    logic    r_busy;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_valid;
    t_result r_result;
    t_result n_result;

    // Datapath signals.
    logic [IDX_W-1:0]         route_len;
    logic                     next_differs;
    logic [IDX_W-1:0]         target;
    logic [ADDR_W-1:0]        tgt_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     wr_en;
    logic [COORD_WIDTH-1:0]   tgt_x;
    logic [COORD_WIDTH-1:0]   tgt_y;
    logic [COORD_WIDTH-1:0]   tgt_z;
    logic                     all_near;
    logic [DWELL_WIDTH:0]     dwell_inc;
    logic                     reached;
    logic                     arrived;

    // True when |p - t| < reach, with the difference taken one bit wider so
    // that it never wraps.
    function automatic logic near_axis(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] t,
        input logic [REACH_W-1:0]            reach
    );
        logic signed [COORD_WIDTH:0] d;
        logic [COORD_WIDTH:0]        a;
        begin
            d = (COORD_WIDTH+1)'(p) - (COORD_WIDTH+1)'(t);
            a = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);
            near_axis = a < (COORD_WIDTH+1)'(reach);
        end
    endfunction

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Route length saturates at the table depth.
    always_comb begin
        if (32'(r_wp_count) > 32'(MAX_WAYPOINTS)) begin
            route_len = IDX_W'(MAX_WAYPOINTS);
        end else begin
            route_len = IDX_W'(r_wp_count);
        end
    end

    // The next set point is a different one only while the index is still on
    // the route; past its end the block just hovers.
    assign next_differs = (route_len != '0) && (r_cur_idx <= route_len);
    assign target       = (r_cur_idx <= route_len) ? r_cur_idx : '0;
    assign tgt_addr     = ADDR_W'(target - IDX_W'(1));

    // Entry zero is the hover point, built from the hover height register.
    always_comb begin
        if (target == '0) begin
            tgt_x = '0;
            tgt_y = '0;
            tgt_z = r_hover;
        end else begin
            tgt_x = r_table_x[tgt_addr];
            tgt_y = r_table_y[tgt_addr];
            tgt_z = r_table_z[tgt_addr];
        end
    end

    assign all_near = near_axis(r_item.pos_x, tgt_x, r_reach_x)
                   && near_axis(r_item.pos_y, tgt_y, r_reach_y)
                   && near_axis(r_item.pos_z, tgt_z, r_reach_z);

    assign dwell_inc = {1'b0, r_dwell} + (DWELL_WIDTH+1)'(1);

    // Sample handling and advance for the item in the input register.
    always_comb begin
        n_dwell   = r_dwell;
        n_cur_idx = r_cur_idx;
        reached   = 1'b0;
        arrived   = 1'b0;
        n_result  = '0;
        case (r_item.op)
            OP_SAMPLE: begin
                if (all_near) begin
                    if (dwell_inc >= {1'b0, r_dwell_count}) begin
                        n_dwell = '0;
                        reached = 1'b1;
                    end else if (dwell_inc[DWELL_WIDTH]) begin
                        n_dwell = '1;
                    end else begin
                        n_dwell = dwell_inc[DWELL_WIDTH-1:0];
                    end
                end else if (r_dwell != '0) begin
                    n_dwell = r_dwell - DWELL_WIDTH'(1);
                end
                arrived             = reached && next_differs;
                n_result.arrived    = arrived;
                n_result.route_done = arrived && (r_cur_idx == route_len);
            end
            OP_ADVANCE: begin
                if (next_differs) begin
                    n_cur_idx = r_cur_idx + IDX_W'(1);
                end
            end
            default: begin
                // Waypoint writes and the unused code leave the index alone.
            end
        endcase
        n_result.current_index = WPC_W'(n_cur_idx);
    end

    // Waypoint write: slot zero and slots beyond the table are dropped.
    assign wr_en   = r_in_valid && (r_item.op == OP_WRITE) && (r_item.slot != '0)
                  && (32'(r_item.slot) <= 32'(MAX_WAYPOINTS));
    assign wr_addr = ADDR_W'(r_item.slot - SLOT_W'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table_x[wr_addr] <= r_item.pos_x;
            r_table_y[wr_addr] <= r_item.pos_y;
            r_table_z[wr_addr] <= r_item.pos_z;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_item <= i_item;
        end
        if (r_in_valid) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b1;
            r_in_valid    <= 1'b0;
            r_valid       <= 1'b0;
            r_cur_idx     <= '0;
            r_dwell       <= '0;
            r_reach_x     <= REACH_RST;
            r_reach_y     <= REACH_RST;
            r_reach_z     <= REACH_RST;
            r_dwell_count <= DWELL_RST;
            r_wp_count    <= WPC_RST;
            r_hover       <= HOVER_RST;
        end else begin
            r_busy     <= 1'b0;
            r_in_valid <= start && !r_busy;
            r_valid    <= r_in_valid;
            if (r_in_valid) begin
                r_cur_idx <= n_cur_idx;
                r_dwell   <= n_dwell;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REACH_X:  r_reach_x     <= i_cfg_data[REACH_W-1:0];
                    CFG_REACH_Y:  r_reach_y     <= i_cfg_data[REACH_W-1:0];
                    CFG_REACH_Z:  r_reach_z     <= i_cfg_data[REACH_W-1:0];
                    CFG_DWELL:    r_dwell_count <= i_cfg_data[DWELL_WIDTH-1:0];
                    CFG_WP_COUNT: r_wp_count    <= i_cfg_data[WPC_W-1:0];
                    CFG_HOVER:    r_hover       <= i_cfg_data[COORD_WIDTH-1:0];
                    default: begin
                        // Indexes beyond the register list are ignored.
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/wpas_checker.sv -----
// Port-level checker for the waypoint arrival sequencer and its bind statement.
`default_nettype none

module wpas_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire               busy,
    input wire               o_valid,
    input wpas_pkg::t_result o_result
);
    import wpas_pkg::*;

    // Every result comes from an accepted item.
    a_valid_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    // Every accepted item gives a result.
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted item gave no result");

    // Reaching the route end is always an arrival.
    a_done_is_arrival: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.route_done) |-> o_result.arrived)
        else $error("route_done without arrived");

    // Back-to-back results move the index by at most one step.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid)) |->
            (o_result.current_index == $past(o_result.current_index)) ||
            (o_result.current_index == $past(o_result.current_index) + WPC_W'(1)))
        else $error("set point index jumped");

endmodule

bind waypoint_arrival_sequencer wpas_checker u_wpas_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// ----- tb/sv/waypoint_arrival_sequencer_tb.sv -----
// Self-checking testbench for the waypoint arrival sequencer: directed and random route flights.
`timescale 1ns / 100ps

module waypoint_arrival_sequencer_tb;
    import wpas_pkg::*;

    // The block has no code for the fourth operation; it must leave all state alone.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // Register indexes past the end of the list, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int ITEM_TARGET    = 1300;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    t_item                   i_item;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    o_valid;
    t_result                 o_result;

    waypoint_arrival_sequencer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Route tracker: the testbench's own copy of the block's state and
    // configuration. It is advanced once per accepted item, at the edge
    // where the item is accepted, so it always reflects every item that
    // the block has taken so far.
    // ------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] route_x [1:MAX_WAYPOINTS];
    logic signed [COORD_WIDTH-1:0] route_y [1:MAX_WAYPOINTS];
    logic signed [COORD_WIDTH-1:0] route_z [1:MAX_WAYPOINTS];
    bit                            wp_loaded [1:MAX_WAYPOINTS];
    logic [WPC_W-1:0]              sp_index;
    logic [DWELL_WIDTH-1:0]        dwell_ctr;

    logic [REACH_W-1:0]            reach_lim_x, reach_lim_y, reach_lim_z;
    logic [DWELL_WIDTH-1:0]        dwell_need;
    logic [WPC_W-1:0]              route_n;
    logic signed [COORD_WIDTH-1:0] hover_z;

    // Expected results, oldest first, and the status predicted for the
    // most recent item (used to steer the random flights).
    t_result pending_progress [$];
    t_result last_progress;
    int      items_sent;
    int      mismatch_count;
    int      burst_left;

    // A route length above the table depth behaves as a full table.
    function automatic int unsigned route_len();
        return (route_n > MAX_WAYPOINTS) ? MAX_WAYPOINTS : route_n;
    endfunction

    // Once the index has run past the route end, the target is the hover point.
    function automatic int unsigned target_entry();
        return (sp_index <= route_len()) ? sp_index : 0;
    endfunction

    // A distinct next set point exists only while the route still has one ahead.
    function automatic bit next_exists();
        return (route_len() >= 1) && (sp_index <= route_len());
    endfunction

    function automatic void entry_point(input int unsigned e,
                                        output logic signed [COORD_WIDTH-1:0] x, y, z);
        if (e == 0 || e > MAX_WAYPOINTS) begin
            x = '0;
            y = '0;
            z = hover_z;
        end else begin
            x = route_x[e];
            y = route_y[e];
            z = route_z[e];
        end
    endfunction

    // The distance is taken at full precision, so a large negative minus a
    // large positive coordinate never wraps into range.
    function automatic bit axis_near(logic signed [COORD_WIDTH-1:0] p,
                                     logic signed [COORD_WIDTH-1:0] t,
                                     logic [REACH_W-1:0] r);
        longint gap;
        gap = longint'(p) - longint'(t);
        if (gap < 0) gap = -gap;
        return gap < longint'({1'b0, r});
    endfunction

    function automatic t_result track_route(t_item it);
        t_result                       res;
        logic signed [COORD_WIDTH-1:0] tx, ty, tz;
        int unsigned                   inc;
        bit                            reached;
        res     = '0;
        reached = 1'b0;
        case (it.op)
            OP_WRITE: begin
                // Slot zero is the hover point and slots past the table are dropped.
                if (it.slot >= 1 && it.slot <= MAX_WAYPOINTS) begin
                    route_x[it.slot]   = it.pos_x;
                    route_y[it.slot]   = it.pos_y;
                    route_z[it.slot]   = it.pos_z;
                    wp_loaded[it.slot] = 1'b1;
                end
            end
            OP_SAMPLE: begin
                entry_point(target_entry(), tx, ty, tz);
                if (axis_near(it.pos_x, tx, reach_lim_x) && axis_near(it.pos_y, ty, reach_lim_y)
                        && axis_near(it.pos_z, tz, reach_lim_z)) begin
                    inc = dwell_ctr + 1;
                    if (inc >= dwell_need) begin
                        dwell_ctr = '0;
                        reached   = 1'b1;
                    end else begin
                        dwell_ctr = (inc > {DWELL_WIDTH{1'b1}}) ? '1 : inc[DWELL_WIDTH-1:0];
                    end
                end else if (dwell_ctr != 0) begin
                    dwell_ctr = dwell_ctr - 1'b1;
                end
                // A reached set point only counts as an arrival when there is
                // somewhere different to go next.
                if (reached && next_exists()) begin
                    res.arrived    = 1'b1;
                    res.route_done = (sp_index == route_len());
                end
            end
            OP_ADVANCE: begin
                if (next_exists()) sp_index = sp_index + 1'b1;
            end
            default: ;
        endcase
        res.current_index = sp_index;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Results cannot be held off, so every cycle with
    // o_valid high carries one result that must match the oldest item
    // still waiting. Values are sampled at the edge, before its register
    // updates land, so they are the ones the edge captured.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_progress.size() == 0) begin
                report_mismatch($sformatf("result with no item waiting: %p", o_result));
            end else begin
                want = pending_progress.pop_front();
                if (o_result.arrived !== want.arrived)
                    report_mismatch($sformatf("arrived got %b want %b",
                                              o_result.arrived, want.arrived));
                if (o_result.route_done !== want.route_done)
                    report_mismatch($sformatf("route_done got %b want %b",
                                              o_result.route_done, want.route_done));
                if (o_result.current_index !== want.current_index)
                    report_mismatch($sformatf("current_index got %0d want %0d",
                                              o_result.current_index, want.current_index));
            end
        end
    end

    // The watchdog ends a run that has stopped making progress: no item
    // taken and no result seen for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $realtime, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic t_item make_item(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                        logic signed [COORD_WIDTH-1:0] x,
                                        logic signed [COORD_WIDTH-1:0] y,
                                        logic signed [COORD_WIDTH-1:0] z);
        t_item it;
        it.op    = op;
        it.slot  = slot;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    // Sends one item and records what it should produce. The caller is
    // always at a rising edge here. start stays high after acceptance so
    // a following item can go back to back; it only drops for a gap
    // between bursts, and the gap always lets time pass before the next
    // item raises it again.
    task automatic send_item(input t_item it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        last_progress = track_route(it);
        pending_progress.push_back(last_progress);
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // Now and then a long burst, so that stretches without gaps occur too.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Every item gives exactly one result, so once nothing is waiting the
    // pipeline is empty and the registers may be rewritten.
    task automatic hold_until_idle();
        start <= 1'b0;
        while (pending_progress.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_REACH_X:  reach_lim_x = val[REACH_W-1:0];
            CFG_REACH_Y:  reach_lim_y = val[REACH_W-1:0];
            CFG_REACH_Z:  reach_lim_z = val[REACH_W-1:0];
            CFG_DWELL:    dwell_need  = val[DWELL_WIDTH-1:0];
            CFG_WP_COUNT: route_n     = val[WPC_W-1:0];
            CFG_HOVER:    hover_z     = val[COORD_WIDTH-1:0];
            default: ;
        endcase
    endtask

    // Rewrites every register, plus the two unused indexes. Bits above
    // each register's width carry random values that the block must drop.
    task automatic program_regs(input logic [REACH_W-1:0] rx, ry, rz,
                                input logic [DWELL_WIDTH-1:0] dw,
                                input logic [WPC_W-1:0] wn,
                                input logic signed [COORD_WIDTH-1:0] hv);
        hold_until_idle();
        write_reg(CFG_REACH_X, {1'($urandom), rx});
        write_reg(CFG_REACH_Y, {1'($urandom), ry});
        write_reg(CFG_REACH_Z, {1'($urandom), rz});
        write_reg(CFG_DWELL, {16'($urandom), dw});
        write_reg(CFG_WP_COUNT, {27'($urandom), wn});
        write_reg(CFG_HOVER, hv);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [REACH_W-1:0] pick_reach();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return REACH_W'($urandom);
            default: return REACH_W'($urandom_range(1, 1 << 18));
        endcase
    endfunction

    function automatic logic [DWELL_WIDTH-1:0] pick_dwell();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return DWELL_WIDTH'($urandom);
            default: return DWELL_WIDTH'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] pick_hover();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(COORD_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(COORD_WIDTH-1){1'b1}}};
            2:       return $urandom;
            default: return $urandom_range(0, 1 << 21) - (1 << 20);
        endcase
    endfunction

    // Waypoints mostly lie within a few hundred metres, sometimes anywhere.
    function automatic logic signed [COORD_WIDTH-1:0] random_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 1 << 25) - (1 << 24);
    endfunction

    // One sample axis aimed at a target: mostly inside the threshold,
    // sometimes exactly on either side of its edge.
    function automatic logic signed [COORD_WIDTH-1:0] aim_axis(logic signed [COORD_WIDTH-1:0] t,
                                                               logic [REACH_W-1:0] r);
        longint span;
        longint off;
        span = (r == 0) ? 1 : longint'(r);
        case ($urandom_range(0, 19))
            0:       off = span;
            1:       off = -span;
            2:       off = span - 1;
            3:       off = 1 - span;
            default: off = longint'($urandom_range(0, 32'(2 * span - 2))) - (span - 1);
        endcase
        return t + COORD_WIDTH'(off);
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Straight out of reset: the route is empty, so the hover point is the
    // target and there is nowhere to go. A sample cannot arrive, an advance
    // does nothing, and the unused operation changes nothing.
    task automatic test_reset_defaults();
        send_item(make_item(OP_SAMPLE, '0, '0, '0, HOVER_RST));
        send_item(make_item(OP_ADVANCE, '1, '1, '1, '1));
        send_item(make_item(OP_UNUSED, '1, '1, '1, '1));
    endtask

    // Writes to the hover slot and past the end of the table are dropped.
    task automatic test_slot_bounds();
        send_item(make_item(OP_WRITE, '0, 32'h8000_0000, 32'h7FFF_FFFF, '1));
        send_item(make_item(OP_WRITE, SLOT_W'(MAX_WAYPOINTS + 1), '1, '0, 32'h8000_0000));
        send_item(make_item(OP_WRITE, '1, 32'h7FFF_FFFF, 32'h8000_0000, '0));
    endtask

    // A two-waypoint route at the coordinate extremes, flown from the hover
    // point through the last waypoint and back onto hover. The x threshold
    // is at its maximum, yet a full-scale x error must still be out of range.
    task automatic test_short_route();
        program_regs('1, REACH_W'(1), REACH_W'(1), DWELL_WIDTH'(1), WPC_W'(2),
                     32'h8000_0000);
        send_item(make_item(OP_WRITE, SLOT_W'(1), 32'h7FFF_FFFF, '0, 32'sd5));
        send_item(make_item(OP_WRITE, SLOT_W'(2), 32'h8000_0000, '1, 32'h7FFF_FFFF));
        send_item(make_item(OP_SAMPLE, '0, '0, '0, 32'h8000_0000));
        send_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
        send_item(make_item(OP_SAMPLE, '0, 32'h7FFF_FFFF, '0, 32'sd5));
        send_item(make_item(OP_SAMPLE, '0, 32'h8000_0000, '0, 32'sd5));
        send_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
        send_item(make_item(OP_SAMPLE, '0, 32'h8000_0000, '1, 32'h7FFF_FFFF));
        send_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
        send_item(make_item(OP_SAMPLE, '0, '0, '0, 32'h8000_0000));
        send_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
    endtask

    // A zero threshold never matches, even on an exact hit. A dwell count of
    // zero reaches on every in-range sample. Shrinking the route below the
    // index leaves the index where it is, targeting hover.
    task automatic test_zero_thresholds();
        program_regs('0, '0, '0, '0, WPC_W'(1), '0);
        send_item(make_item(OP_SAMPLE, '0, '0, '0, '0));
        program_regs(REACH_W'(1), REACH_W'(1), REACH_W'(1), '0, WPC_W'(1), '0);
        send_item(make_item(OP_SAMPLE, '0, '0, '0, '0));
        send_item(make_item(OP_ADVANCE, '0, '0, '0, '0));
    endtask

    // Random flights. Each phase picks new settings, loads any waypoint the
    // route needs that was never written (so no sample ever targets an empty
    // entry), then flies: mostly samples aimed at the current set point,
    // advances after arrivals, and some noise. Advances per phase are
    // rationed so the index climbs slowly across the whole run, and the
    // route length is often grown just ahead of the index so that later
    // waypoints and the route end are reached.
    task automatic test_random_routes();
        int unsigned                   steps, pick, moves_left, grow;
        logic [WPC_W-1:0]              n_new;
        logic signed [COORD_WIDTH-1:0] tx, ty, tz;
        t_item                         it;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: n_new = '0;
                1: n_new = WPC_W'($urandom_range(MAX_WAYPOINTS + 1, 31));
                2: n_new = (sp_index > 2) ? sp_index - 2'd2 : WPC_W'(1);
                default: begin
                    grow  = sp_index + $urandom_range(0, 3);
                    n_new = (grow > MAX_WAYPOINTS) ? WPC_W'(MAX_WAYPOINTS) : WPC_W'(grow);
                end
            endcase
            program_regs(pick_reach(), pick_reach(), pick_reach(), pick_dwell(), n_new,
                         pick_hover());
            for (int s = 1; s <= MAX_WAYPOINTS; s++) begin
                if (s <= route_len() && !wp_loaded[s])
                    send_item(make_item(OP_WRITE, SLOT_W'(s), random_coord(), random_coord(),
                                        random_coord()));
            end
            moves_left = $urandom_range(0, 2);
            steps      = $urandom_range(30, 80);
            for (int k = 0; k < steps; k++) begin
                pick = $urandom_range(0, 99);
                if (moves_left > 0 && ((last_progress.arrived && pick < 80) || pick < 3)) begin
                    it = make_item(OP_ADVANCE, SLOT_W'($urandom), $urandom, $urandom, $urandom);
                    moves_left--;
                end else if (pick < 72) begin
                    entry_point(target_entry(), tx, ty, tz);
                    it = make_item(OP_SAMPLE, SLOT_W'($urandom), aim_axis(tx, reach_lim_x),
                                   aim_axis(ty, reach_lim_y), aim_axis(tz, reach_lim_z));
                end else if (pick < 82) begin
                    it = make_item(OP_SAMPLE, SLOT_W'($urandom), $urandom, $urandom, $urandom);
                end else if (pick < 94) begin
                    // Any slot, including the hover slot and those past the table.
                    it = make_item(OP_WRITE, SLOT_W'($urandom), random_coord(), random_coord(),
                                   random_coord());
                end else begin
                    it = make_item(OP_UNUSED, SLOT_W'($urandom), $urandom, $urandom, $urandom);
                end
                send_item(it);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;

        // The tracker starts from the block's reset state.
        sp_index       = '0;
        dwell_ctr      = '0;
        reach_lim_x    = REACH_RST;
        reach_lim_y    = REACH_RST;
        reach_lim_z    = REACH_RST;
        dwell_need     = DWELL_RST;
        route_n        = WPC_RST;
        hover_z        = HOVER_RST;
        last_progress  = '0;
        items_sent     = 0;
        mismatch_count = 0;
        burst_left     = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_slot_bounds();
        test_short_route();
        test_zero_thresholds();
        test_random_routes();

        // Let the last results drain, and give anything stray time to show.
        hold_until_idle();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
